// ----- hw/rtl/tqr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqr_pkg: shared types and constants for the thread queue
// Operation and status codes, field widths, and the control bundle that the
// controller passes to the datapath.
// ----------------------------------------------------------------------------
package tqr_pkg;

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 16;
  localparam int IDENT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture the transaction and the per-cell match vector
    logic commit;  // update the cells and the count, register the result
  } tqr_cmd_t;

endpackage

// ----- hw/rtl/tqr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqr_ctrl: thread queue controller
// Two-state sequencer: accepts a transaction, commits it in the next cycle and
// raises the result strobe in the cycle after that.
// ----------------------------------------------------------------------------
module tqr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output tqr_pkg::tqr_cmd_t cmd
);
  import tqr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;

  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.commit = (state_r == S_COMMIT);
  assign busy       = busy_r;
  assign out_valid  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_COMMIT;
            busy_r  <= 1'b1;
          end
        end
        S_COMMIT: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  // Every accepted transaction is committed in the next cycle.
  a_accept_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.commit)
    else $error("accepted transaction was not committed");

  // The result strobe follows each commit in the next cycle.
  a_commit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result strobe");

  // The busy flag mirrors the commit cycle.
  a_busy_commit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == cmd.commit)
    else $error("busy flag out of step with the sequencer");

endmodule

// ----- hw/rtl/tqr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqr_dp: thread queue datapath
// A compacting row of cells with one comparator per cell, a first-match
// select, the shift that closes a gap, and the registered result.
// ----------------------------------------------------------------------------
module tqr_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tqr_pkg::tqr_cmd_t             cmd,
  input  logic [tqr_pkg::OP_W-1:0]      in_op,
  input  logic [tqr_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [tqr_pkg::IDENT_W-1:0]   in_thread_id,
  output logic [tqr_pkg::HANDLE_W-1:0]  out_result_handle,
  output logic [tqr_pkg::STATUS_W-1:0]  out_status,
  output logic [tqr_pkg::OCC_W-1:0]     out_occupancy
);
  import tqr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [HANDLE_W-1:0] hnd_r [DEPTH];
  logic [IDENT_W-1:0]  idn_r [DEPTH];
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;

  logic [OP_W-1:0]     op_r;
  logic [HANDLE_W-1:0] key_hnd_r;
  logic [IDENT_W-1:0]  key_idn_r;
  logic [DEPTH-1:0]    match_r;
  logic [DEPTH-1:0]    match_nxt;

  logic [HANDLE_W-1:0] res_r;
  logic [STATUS_W-1:0] st_r;
  logic [OCC_W-1:0]    occ_r;

  logic [DEPTH-1:0]    first;
  logic [DEPTH-1:0]    below;
  logic                hit;
  logic                full;
  logic                do_push;
  logic                do_drop;
  logic [HANDLE_W-1:0] sel_hnd;
  logic [HANDLE_W-1:0] res_nxt;
  logic [STATUS_W-1:0] st_nxt;

  // One comparator per cell against the incoming key; only occupied cells
  // may match. A pop always targets the head.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (in_op == OP_POP) begin
        match_nxt[i] = (i == 0) && (count_r != '0);
      end else if (in_op == OP_REMOVE) begin
        match_nxt[i] = (count_r > CW'(i)) && (hnd_r[i] == in_handle);
      end else begin
        match_nxt[i] = (count_r > CW'(i)) && (idn_r[i] == in_thread_id);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      key_hnd_r <= in_handle;
      key_idn_r <= in_thread_id;
      match_r   <= match_nxt;
    end
  end

  // Isolate the lowest match; cells at or above it take their upper
  // neighbor when an entry is dropped.
  assign first = match_r & (~match_r + DEPTH'(1));
  assign below = first - DEPTH'(1);
  assign hit   = |match_r;
  assign full  = (count_r >= CW'(DEPTH));

  assign do_push = cmd.commit && (op_r == OP_PUSH) && !full;
  assign do_drop = cmd.commit && ((op_r == OP_POP) || (op_r == OP_REMOVE)) && hit;

  always_comb begin
    sel_hnd = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        sel_hnd = sel_hnd | hnd_r[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    res_nxt   = '0;
    st_nxt    = ST_OK;
    case (op_r)
      OP_PUSH: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP: begin
        if (hit) begin
          res_nxt   = sel_hnd;
          count_nxt = count_r - CW'(1);
        end else begin
          st_nxt = ST_NONE;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          count_nxt = count_r - CW'(1);
        end else begin
          st_nxt = ST_NONE;
        end
      end
      OP_FIND: begin
        if (hit) begin
          res_nxt = sel_hnd;
        end else begin
          st_nxt = ST_NONE;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (do_push && (count_r == CW'(g))) begin
          hnd_r[g] <= key_hnd_r;
          idn_r[g] <= key_idn_r;
        end else if (do_drop && !below[g]) begin
          hnd_r[g] <= hnd_r[g+1];
          idn_r[g] <= idn_r[g+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (do_push && (count_r == CW'(g))) begin
          hnd_r[g] <= key_hnd_r;
          idn_r[g] <= key_idn_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
      occ_r <= OCC_W'(count_nxt);
    end
  end

  assign out_result_handle = res_r;
  assign out_status        = st_r;
  assign out_occupancy     = occ_r;

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  // Only occupied cells can match, so a pending drop always has an entry.
  a_match_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    do_drop |-> (count_r != '0))
    else $error("drop on an empty queue");

  // A commit moves the count by at most one, except for a clear.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r != OP_CLEAR)) |=>
      (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
      (count_r == $past(count_r) - CW'(1)))
    else $error("queue count jumped");

endmodule

// ----- hw/rtl/thread_queue_with_removal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_queue_with_removal: ordered thread queue with removal by handle
// A FIFO of (handle, identifier) entries held in a compacting row of cells.
// Supports push, pop of the head, removal by handle, find by identifier and
// clear. Each transaction yields exactly one result.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   -------------------------------------------
//   input     start / busy         in_op, in_handle, in_thread_id
//   result    out_valid (strobe)   out_result_handle, out_status, out_occupancy
//
// A transaction is taken on a clock edge where start is high and busy is low.
// The cycle after acceptance is the commit cycle (busy high): every cell
// compared against the key at acceptance, so the commit picks the first match,
// shifts the later cells one place toward the head and updates the count.
// The result strobe follows in the next cycle, during which a new transaction
// can already be accepted; the compare-then-commit sequence of the cell row
// keeps busy high, and new transactions out, during the commit cycle.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset is synchronous and active low; it empties the queue at once (the
// cell contents are left as they are and are never read while unoccupied).
//
module thread_queue_with_removal #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tqr_pkg::OP_W-1:0]      in_op,
  input  logic [tqr_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [tqr_pkg::IDENT_W-1:0]   in_thread_id,
  output logic                          out_valid,
  output logic [tqr_pkg::HANDLE_W-1:0]  out_result_handle,
  output logic [tqr_pkg::STATUS_W-1:0]  out_status,
  output logic [tqr_pkg::OCC_W-1:0]     out_occupancy
);
  import tqr_pkg::*;

  // Command bundle from the sequencer to the cell row.
  tqr_cmd_t cmd;

  // The controller owns the handshake and the result strobe.
  tqr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // The datapath owns the cells, the count and the result registers.
  tqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_handle         (in_handle),
    .in_thread_id      (in_thread_id),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

endmodule

// ----- bench/tqr_tracker_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqr_tracker_pkg: scoreboard for the thread queue bench
// Keeps a copy of the queue contents and predicts the result of every
// transaction. Each strobed result is then checked against the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
package tqr_tracker_pkg;

  import tqr_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } queue_reply_t;

  class queue_tracker;
    logic [HANDLE_W-1:0] cell_handle[QUEUE_DEPTH];
    logic [IDENT_W-1:0]  cell_ident[QUEUE_DEPTH];
    int                  cell_count;
    queue_reply_t        pending_replies[$];
    int                  mismatches;
    int                  replies_checked;
    int                  ignored_ops;
    int                  full_pushes;
    int                  hits;
    int                  peak_count;
    int                  op_seen[5];

    // Deletes one cell and closes the gap, keeping the order of the rest.
    function void drop_cell(int pos);
      for (int i = pos; i + 1 < cell_count; i++) begin
        cell_handle[i] = cell_handle[i + 1];
        cell_ident[i]  = cell_ident[i + 1];
      end
      cell_count--;
    endfunction

    // Applies an accepted transaction to the copy and queues its result.
    function void note_op(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                          logic [IDENT_W-1:0] ident);
      queue_reply_t reply;
      int           pos;
      reply        = '0;
      reply.status = ST_OK;
      pos          = -1;
      case (op)
        OP_PUSH: begin
          if (cell_count >= QUEUE_DEPTH) begin
            reply.status = ST_FULL;
            full_pushes++;
          end else begin
            cell_handle[cell_count] = handle;
            cell_ident[cell_count]  = ident;
            cell_count++;
          end
        end
        OP_POP: begin
          if (cell_count == 0) begin
            reply.status = ST_NONE;
          end else begin
            reply.handle = cell_handle[0];
            drop_cell(0);
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < cell_count; i++)
            if (pos < 0 && cell_handle[i] == handle) pos = i;
          if (pos < 0) begin
            reply.status = ST_NONE;
          end else begin
            drop_cell(pos);
            hits++;
          end
        end
        OP_FIND: begin
          for (int i = 0; i < cell_count; i++)
            if (pos < 0 && cell_ident[i] == ident) pos = i;
          if (pos < 0) begin
            reply.status = ST_NONE;
          end else begin
            reply.handle = cell_handle[pos];
            hits++;
          end
        end
        OP_CLEAR: begin
          cell_count = 0;
        end
        default: begin
          ignored_ops++;
        end
      endcase
      if (op <= OP_CLEAR) op_seen[op]++;
      if (cell_count > peak_count) peak_count = cell_count;
      reply.occupancy = OCC_W'(cell_count);
      pending_replies.push_back(reply);
    endfunction

    // Compares one strobed result with the oldest outstanding prediction.
    function void check_reply(logic [HANDLE_W-1:0] handle, logic [STATUS_W-1:0] status,
                              logic [OCC_W-1:0] occupancy);
      queue_reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result with no transaction outstanding: handle %h status %0d occ %0d",
                   $time, handle, status, occupancy);
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (handle !== want.handle || status !== want.status ||
          occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result %0d: expected handle %h status %0d occ %0d, got %h %0d %0d",
                   $time, replies_checked, want.handle, want.status, want.occupancy,
                   handle, status, occupancy);
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_thread_queue_with_removal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thread_queue_with_removal: self-checking bench for the thread queue
// Drives push, pop, remove, find, clear and unused operation codes through
// the start/busy port, first a directed sequence over the corner cases and
// then about a thousand random transactions that swing the queue between
// empty and full. A scoreboard predicts every result and checks the strobed
// output in order.
// ----------------------------------------------------------------------------
module tb_thread_queue_with_removal;

  import tqr_pkg::*;
  import tqr_tracker_pkg::*;

  localparam int RANDOM_OPS = 1050;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_op;
  logic [HANDLE_W-1:0] in_handle;
  logic [IDENT_W-1:0]  in_thread_id;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_result_handle;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occupancy;

  queue_tracker tracker = new();

  // Transactions left in the current burst of back-to-back requests.
  int burst_left = 0;

  thread_queue_with_removal #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_handle         (in_handle),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops answering or never drops busy.
  initial begin
    #2_000_000;
    $display("thread_queue_with_removal test failed");
    $finish;
  end

  // Monitor. All stimulus is driven with nonblocking assignments, so at the
  // clock edge this block sees the values that the block itself samples.
  // A transaction is taken when start is high and busy is low; every strobed
  // result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && start && !busy) tracker.note_op(in_op, in_handle, in_thread_id);
    if (rst_n && out_valid) tracker.check_reply(out_result_handle, out_status, out_occupancy);
  end

  // Releases the request line for a number of cycles.
  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Presents one transaction and returns at the edge that accepts it. The
  // request line stays high into the next transaction of a burst; between
  // bursts a random gap is inserted, and some bursts follow with no gap at all
  // so the block also sees long stretches of back-to-back requests.
  task automatic send(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
                      input logic [IDENT_W-1:0] ident);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
    burst_left--;
    start        <= 1'b1;
    in_op        <= op;
    in_handle    <= handle;
    in_thread_id <= ident;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Key values: mostly a small range so that removes and finds hit and
  // identifiers repeat, plus the all-zero and all-one patterns and full-range
  // values so that every bit toggles.
  function automatic logic [HANDLE_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return HANDLE_W'($urandom_range(0, 15));
    if (pick == 5) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return HANDLE_W'($urandom());
  endfunction

  initial begin
    int                  counted;
    int                  roll;
    int                  slack;
    bit                  filling;
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [IDENT_W-1:0]  ident;

    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= OP_PUSH;
    in_handle    <= '0;
    in_thread_id <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Empty-queue pop and remove, then fill the queue to the
    // brim with extreme handles and identifiers (including a handle of zero
    // and repeated identifiers), refuse one push on the full queue, find the
    // first of several equal identifiers, miss a find, remove from the middle,
    // pop the head, try an unused code and clear.
    send(OP_POP, '0, '0);
    send(OP_REMOVE, '0, '0);
    send(OP_PUSH, 16'h0000, 16'hFFFF);
    send(OP_PUSH, 16'hFFFF, 16'h0000);
    send(OP_PUSH, 16'hAAAA, 16'h5555);
    send(OP_PUSH, 16'h5555, 16'hAAAA);
    for (int i = 0; i < QUEUE_DEPTH - 4; i++)
      send(OP_PUSH, HANDLE_W'(16'h1000 + i), IDENT_W'(i % 3));
    send(OP_PUSH, 16'h1234, 16'h1234);
    send(OP_FIND, '0, 16'h0000);
    send(OP_FIND, '0, 16'h7777);
    send(OP_REMOVE, 16'h5555, '0);
    send(OP_POP, '0, '0);
    send(3'(2 ** OP_W - 1), pick_value(), pick_value());
    send(OP_CLEAR, '0, '0);

    // Random part. The mix leans toward pushes until the queue fills, then
    // toward pops and removes until it drains, so that both the full and the
    // empty corner are visited many times. Removes and finds mostly use a key
    // that is in the queue right now. Unused codes are not counted.
    filling = 1'b1;
    counted = 0;
    while (counted < RANDOM_OPS) begin
      if (tracker.cell_count >= QUEUE_DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (tracker.cell_count == 0) filling = 1'b1;
      roll   = $urandom_range(0, 99);
      handle = pick_value();
      ident  = pick_value();
      if (filling)
        op = (roll < 55) ? OP_PUSH : (roll < 65) ? OP_POP : (roll < 80) ? OP_REMOVE :
             (roll < 96) ? OP_FIND : (roll < 97) ? OP_CLEAR : OP_CLEAR + 3'd1;
      else
        op = (roll < 20) ? OP_PUSH : (roll < 50) ? OP_POP : (roll < 80) ? OP_REMOVE :
             (roll < 95) ? OP_FIND : (roll < 97) ? OP_CLEAR : OP_CLEAR + 3'd1;
      if (op > OP_CLEAR) op = 3'($urandom_range(int'(OP_CLEAR) + 1, 2 ** OP_W - 1));
      if (tracker.cell_count > 0 && $urandom_range(0, 9) < 7) begin
        handle = tracker.cell_handle[$urandom_range(0, tracker.cell_count - 1)];
        ident  = tracker.cell_ident[$urandom_range(0, tracker.cell_count - 1)];
      end
      send(op, handle, ident);
      if (op <= OP_CLEAR) counted++;
    end

    // Drain: wait for every outstanding result, then a few more cycles so
    // that a stray extra strobe would still be caught.
    start <= 1'b0;
    slack = 0;
    while (tracker.pending_replies.size() != 0 && slack < 1000) begin
      @(posedge clk);
      slack++;
    end
    repeat (4) @(posedge clk);

    $display("Ran %0d transactions: push %0d, pop %0d, remove %0d, find %0d,",
             tracker.replies_checked, tracker.op_seen[OP_PUSH], tracker.op_seen[OP_POP],
             tracker.op_seen[OP_REMOVE], tracker.op_seen[OP_FIND]);
    $display("  clear %0d, unused %0d, pushes refused when full %0d, remove/find hits %0d,",
             tracker.op_seen[OP_CLEAR], tracker.ignored_ops, tracker.full_pushes,
             tracker.hits);
    $display("  peak occupancy %0d, mismatches %0d.",
             tracker.peak_count, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("thread_queue_with_removal test passed");
    end else begin
      $display("thread_queue_with_removal test failed");
    end
    $finish;
  end

endmodule
